/* hw/rtl/deq_pkg.sv */
package deq_pkg;

  localparam int Depth = 32;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int WordW = 32;
  localparam int FillW = 6;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [2:0] {
    ActPushBack  = 3'd0,
    ActPushFront = 3'd1,
    ActPopFront  = 3'd2,
    ActPopBack   = 3'd3,
    ActClear     = 3'd4,
    ActDump      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [WordW-1:0] word_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [WordW-1:0] word_out;
    logic [FillW-1:0]        fill;
    logic                    last;
  } out_beat_t;

  // Ring position of the entry that lies off entries behind idx.
  function automatic idx_t wrap_add(idx_t idx, cnt_t off);
    logic [IdxW:0] sum;
    sum = {1'b0, idx} + (IdxW + 1)'(off);
    if (sum >= (IdxW + 1)'(Depth)) begin
      sum = sum - (IdxW + 1)'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

/* hw/rtl/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit words kept in a ring memory.
// The input channel carries one action per beat: push back, push front,
// pop front, pop back, clear or dump. The output channel returns result
// beats with a status, a word, the fill after the action and a last flag.
// Push, pop and clear give one result beat in the cycle after acceptance, and
// such actions can be accepted in every cycle while the output drains.
// A dump of n held words gives n beats: it first enters its dump state and
// issues the first memory read, then gives one beat per cycle while the
// receiver does not stall; the single read port of the ring memory sets that
// pace. No new action is accepted until the final dump beat has been loaded.
// A push onto a full queue is refused with status full, and a pop or dump
// of an empty queue reports status empty with an unchanged state.
// Reset empties the queue and the output register at once; the memory
// contents are not cleared, since only held entries are ever read.
// While the receiver stalls, the output beat holds and the block stops
// taking new actions once its single output register is full.
module double_ended_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  deq_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output deq_pkg::out_beat_t  out_beat_o
);
  import deq_pkg::*;

  typedef enum logic {
    StIdle,
    StDump
  } state_e;

  state_e    state_q, state_d;
  idx_t      front_q, front_d;
  cnt_t      count_q, count_d;
  cnt_t      rd_off_q, rd_off_d;
  logic      rd_pend_q, rd_pend_d;
  logic      pend_last_q, pend_last_d;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_q, out_d;

  logic             out_free;
  logic             in_accept;
  logic             ram_we;
  idx_t             ram_waddr;
  logic             ram_re;
  idx_t             ram_raddr;
  logic [WordW-1:0] ram_rdata;
  logic             loaded;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    rd_off_d    = rd_off_q;
    rd_pend_d   = rd_pend_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = front_q;
    ram_re      = 1'b0;
    ram_raddr   = front_q;
    loaded      = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          out_valid_d    = 1'b1;
          out_d.status   = StOk;
          out_d.word_out = '0;
          out_d.last     = 1'b1;
          case (action_e'(in_beat_i.action))
            ActPushBack: begin
              if (count_q == CntW'(Depth)) begin
                out_d.status = StFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(front_q, count_q);
                count_d   = count_q + CntW'(1);
              end
            end
            ActPushFront: begin
              if (count_q == CntW'(Depth)) begin
                out_d.status = StFull;
              end else begin
                front_d   = (front_q == '0) ? IdxW'(Depth - 1) : front_q - IdxW'(1);
                ram_we    = 1'b1;
                ram_waddr = front_d;
                count_d   = count_q + CntW'(1);
              end
            end
            ActPopFront: begin
              if (count_q == '0) begin
                out_d.status = StEmpty;
              end else begin
                front_d = wrap_add(front_q, CntW'(1));
                count_d = count_q - CntW'(1);
              end
            end
            ActPopBack: begin
              if (count_q == '0) begin
                out_d.status = StEmpty;
              end else begin
                count_d = count_q - CntW'(1);
              end
            end
            ActClear: begin
              front_d = '0;
              count_d = '0;
            end
            ActDump: begin
              if (count_q == '0) begin
                out_d.status = StEmpty;
              end else begin
                out_valid_d = out_valid_q && out_stall_i;
                state_d     = StDump;
                rd_off_d    = '0;
                rd_pend_d   = 1'b0;
              end
            end
            default: begin
            end
          endcase
          out_d.fill = FillW'(count_d);
        end
      end
      StDump: begin
        if (rd_pend_q && out_free) begin
          loaded         = 1'b1;
          out_valid_d    = 1'b1;
          out_d.status   = StOk;
          out_d.word_out = ram_rdata;
          out_d.fill     = FillW'(count_q);
          out_d.last     = pend_last_q;
          rd_pend_d      = 1'b0;
          if (pend_last_q) begin
            state_d = StIdle;
          end
        end
        if ((rd_off_q < count_q) && (!rd_pend_q || loaded)) begin
          ram_re      = 1'b1;
          ram_raddr   = wrap_add(front_q, rd_off_q);
          rd_off_d    = rd_off_q + CntW'(1);
          rd_pend_d   = 1'b1;
          pend_last_d = (rd_off_q == count_q - CntW'(1));
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      front_q     <= '0;
      count_q     <= '0;
      rd_off_q    <= '0;
      rd_pend_q   <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      rd_off_q    <= rd_off_d;
      rd_pend_q   <= rd_pend_d;
      pend_last_q <= pend_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  deq_ram #(
    .Width (WordW),
    .Depth (Depth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_beat_i.word_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

/* hw/rtl/deq_ram.sv */
module deq_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
